[rtl/x64_instruction_byte_encoder_macros.svh]
// ----------------------------------------------------------------------------
// x64 instruction byte encoder assertion macros
// Concurrent checks sampled on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef X64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH
`define X64_INSTRUCTION_BYTE_ENCODER_MACROS_SVH

// consequent in the same cycle
`define X64E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define X64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/x64e_pkg.sv]
// ----------------------------------------------------------------------------
// x64e_pkg
// Shared types, opcode constants and field helpers of the byte encoder.
// ----------------------------------------------------------------------------
package x64e_pkg;

  localparam int unsigned ENC_MAX_BYTES = 10;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [4:0] {
    OP_MOV      = 5'd0,
    OP_CALLREG  = 5'd1,
    OP_CALLREL  = 5'd2,
    OP_RET      = 5'd3,
    OP_CMPIMM   = 5'd4,
    OP_CMPREG   = 5'd5,
    OP_JCC      = 5'd6,
    OP_JMPREL   = 5'd7,
    OP_JMPRIP   = 5'd8,
    OP_JMPREG   = 5'd9,
    OP_REGREG   = 5'd10,
    OP_MEMSIB   = 5'd11,
    OP_MEM      = 5'd12,
    OP_OPIMM    = 5'd13,
    OP_ARITHIMM = 5'd14,
    OP_PUSH     = 5'd15,
    OP_POP      = 5'd16,
    OP_CMOVL    = 5'd17
  } op_e;

  localparam logic [7:0] REX_BASE        = 8'h40;
  localparam logic [7:0] OPC_MOV_IMM     = 8'hB8;
  localparam logic [7:0] OPC_GRP1_IMM32  = 8'h81;
  localparam logic [7:0] OPC_GRP1_IMM8   = 8'h83;
  localparam logic [7:0] OPC_CMP_RM      = 8'h3B;
  localparam logic [7:0] OPC_CALL_REL    = 8'hE8;
  localparam logic [7:0] OPC_JMP_REL     = 8'hE9;
  localparam logic [7:0] OPC_RET         = 8'hC3;
  localparam logic [7:0] OPC_POP_RM      = 8'h8F;
  localparam logic [7:0] OPC_CMOVL       = 8'h4C;
  localparam logic [7:0] OPC_ESC         = 8'h0F;
  localparam logic [7:0] OPC_GRP5        = 8'hFF;
  localparam logic [7:0] OPC_PUSH        = 8'h50;
  localparam logic [7:0] JCC_SHORT_DELTA = 8'h10;

  localparam logic [2:0] EXT_CALL = 3'd2;
  localparam logic [2:0] EXT_JMP  = 3'd4;
  localparam logic [2:0] EXT_CMP  = 3'd7;
  localparam logic [2:0] EXT_POP  = 3'd0;

  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_SIB   = 3'd4;
  localparam logic [2:0] RM_RIP   = 3'd5;
  localparam logic [3:0] IDX_NONE = 4'd4;

  typedef logic [ENC_MAX_BYTES-1:0][7:0] enc_bytes_t;

  typedef struct packed {
    enc_bytes_t       bytes;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [7:0]       code;
    logic [LEN_W-1:0] pos;
    logic             last;
  } result_t;

  function automatic logic fits8(input logic [31:0] v);
    return (v[31:7] == '0) || (v[31:7] == '1);
  endfunction

  function automatic logic [7:0] rex(input logic w, input logic r, input logic x,
                                     input logic b);
    return REX_BASE | {4'h0, w, r, x, b};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] reg_f,
                                       input logic [2:0] rm_f);
    return {md, reg_f, rm_f};
  endfunction

endpackage

[rtl/x64_instruction_byte_encoder.sv]
// ----------------------------------------------------------------------------
// x64_instruction_byte_encoder: one request in, its x86-64 bytes out
// A request passes the front register, the queue and the back registers,
// then goes out one byte per cycle, 1 to 10; requests queue while one is sent.
// Reset clears all control; no strobe until a request has been taken.
// ----------------------------------------------------------------------------
`include "x64_instruction_byte_encoder_macros.svh"

module x64_instruction_byte_encoder #(
  parameter int unsigned QueueDepth = x64e_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [4:0]                     op_i,
  input  logic [7:0]                     opcode_byte_i,
  input  logic [3:0]                     reg_field_i,
  input  logic [3:0]                     rm_register_i,
  input  logic [3:0]                     index_register_i,
  input  logic [1:0]                     scale_code_i,
  input  logic [7:0]                     cond_byte_i,
  input  logic [2:0]                     ext_code_i,
  input  logic signed [63:0]             imm_value_i,
  input  logic signed [31:0]             displacement_i,
  output logic                           result_valid_o,
  output logic [7:0]                     code_byte_o,
  output logic [x64e_pkg::LEN_W-1:0]     byte_position_o,
  output logic                           last_byte_o
);
  import x64e_pkg::*;

  logic    front_ready;
  logic    push;
  entry_t  front_entry;
  logic    q_full;
  logic    q_valid;
  entry_t  q_data;
  logic    pop;
  result_t res;

  x64e_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .ready_o         (front_ready),
    .op_i            (op_i),
    .opcode_byte_i   (opcode_byte_i),
    .reg_field_i     (reg_field_i),
    .rm_register_i   (rm_register_i),
    .index_register_i(index_register_i),
    .scale_code_i    (scale_code_i),
    .cond_byte_i     (cond_byte_i),
    .ext_code_i      (ext_code_i),
    .imm_value_i     (imm_value_i),
    .displacement_i  (displacement_i),
    .push_o          (push),
    .entry_o         (front_entry),
    .q_full_i        (q_full)
  );

  x64e_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  x64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .res_valid_o(result_valid_o),
    .res_o      (res)
  );

  assign busy            = !front_ready;
  assign code_byte_o     = res.code;
  assign byte_position_o = res.pos;
  assign last_byte_o     = res.last;

  `X64E_ASSERT_NEXT(a_bytes_contiguous, result_valid_o && !last_byte_o, result_valid_o && (byte_position_o == LEN_W'($past(byte_position_o) + 1'b1)), "instruction bytes not contiguous")

  `X64E_ASSERT_NEXT(a_new_item_at_zero, !result_valid_o || last_byte_o, !result_valid_o || (byte_position_o == '0), "instruction does not start at byte zero")

  `X64E_ASSERT_NOW(a_length_cap, result_valid_o && (byte_position_o == LEN_W'(ENC_MAX_BYTES - 1)), last_byte_o, "instruction longer than ten bytes")

endmodule

[rtl/x64e_front.sv]
// ----------------------------------------------------------------------------
// x64e_front
// Accepts a request, picks the encoding and registers the finished bytes.
// ----------------------------------------------------------------------------
module x64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                ready_o,
  input  logic [4:0]          op_i,
  input  logic [7:0]          opcode_byte_i,
  input  logic [3:0]          reg_field_i,
  input  logic [3:0]          rm_register_i,
  input  logic [3:0]          index_register_i,
  input  logic [1:0]          scale_code_i,
  input  logic [7:0]          cond_byte_i,
  input  logic [2:0]          ext_code_i,
  input  logic signed [63:0]  imm_value_i,
  input  logic signed [31:0]  displacement_i,
  output logic                push_o,
  output x64e_pkg::entry_t    entry_o,
  input  logic                q_full_i
);
  import x64e_pkg::*;

  enc_bytes_t       bytes;
  logic [LEN_W-1:0] len;
  logic [31:0]      disp;
  logic [31:0]      imm32;
  logic             disp_s8;
  logic             imm_s8;
  logic             imm_wide;
  logic [1:0]       mem_mod;
  logic             sib_form;
  logic [3:0]       sib_idx;
  logic [1:0]       sib_scale;
  logic [7:0]       grp_ext_reg;
  logic [2:0]       grp_ext;

  logic   valid_q;
  entry_t entry_q;
  logic   take;

  assign disp      = displacement_i;
  assign imm32     = imm_value_i[31:0];
  assign disp_s8   = fits8(disp);
  assign imm_s8    = fits8(imm32);
  assign imm_wide  = !((imm_value_i[63:31] == '0) || (imm_value_i[63:31] == '1));
  assign mem_mod   = disp_s8 ? MOD_DISP8 : MOD_DISP32;
  assign sib_form  = (op_e'(op_i) == OP_MEMSIB) || (rm_register_i[2:0] == RM_SIB);
  assign sib_idx   = (op_e'(op_i) == OP_MEMSIB) ? index_register_i : IDX_NONE;
  assign sib_scale = (op_e'(op_i) == OP_MEMSIB) ? scale_code_i : 2'd0;
  assign grp_ext   = (op_e'(op_i) == OP_CMPIMM) ? EXT_CMP : ext_code_i;
  assign grp_ext_reg = imm_s8 ? OPC_GRP1_IMM8 : OPC_GRP1_IMM32;

  always_comb begin
    bytes = '0;
    len   = '0;
    case (op_e'(op_i))
      OP_MOV: begin
        bytes[0] = rex(imm_wide, 1'b0, 1'b0, rm_register_i[3]);
        bytes[1] = OPC_MOV_IMM | {5'd0, rm_register_i[2:0]};
        if (imm_wide) begin
          bytes[9:2] = imm_value_i;
          len        = LEN_W'(10);
        end else begin
          bytes[5:2] = imm32;
          len        = LEN_W'(6);
        end
      end
      OP_CALLREG: begin
        bytes[0] = rex(1'b1, 1'b0, 1'b0, rm_register_i[3]);
        bytes[1] = OPC_GRP5;
        bytes[2] = modrm(MOD_REG, EXT_CALL, rm_register_i[2:0]);
        len      = LEN_W'(3);
      end
      OP_CALLREL: begin
        bytes[0]   = OPC_CALL_REL;
        bytes[4:1] = disp;
        len        = LEN_W'(5);
      end
      OP_RET: begin
        bytes[0] = OPC_RET;
        len      = LEN_W'(1);
      end
      OP_CMPIMM, OP_ARITHIMM: begin
        bytes[0] = rex(1'b1, 1'b0, 1'b0, rm_register_i[3]);
        bytes[1] = grp_ext_reg;
        bytes[2] = modrm(MOD_REG, grp_ext, rm_register_i[2:0]);
        if (imm_s8) begin
          bytes[3] = imm32[7:0];
          len      = LEN_W'(4);
        end else begin
          bytes[6:3] = imm32;
          len        = LEN_W'(7);
        end
      end
      OP_CMPREG: begin
        bytes[0] = rex(1'b1, reg_field_i[3], 1'b0, rm_register_i[3]);
        bytes[1] = OPC_CMP_RM;
        bytes[2] = modrm(MOD_REG, reg_field_i[2:0], rm_register_i[2:0]);
        len      = LEN_W'(3);
      end
      OP_JCC: begin
        if (disp_s8) begin
          bytes[0] = cond_byte_i - JCC_SHORT_DELTA;
          bytes[1] = disp[7:0];
          len      = LEN_W'(2);
        end else begin
          bytes[0]   = OPC_ESC;
          bytes[1]   = cond_byte_i;
          bytes[5:2] = disp;
          len        = LEN_W'(6);
        end
      end
      OP_JMPREL: begin
        bytes[0]   = OPC_JMP_REL;
        bytes[4:1] = disp;
        len        = LEN_W'(5);
      end
      OP_JMPRIP: begin
        bytes[0]   = OPC_GRP5;
        bytes[1]   = modrm(MOD_IND, EXT_JMP, RM_RIP);
        bytes[5:2] = disp;
        len        = LEN_W'(6);
      end
      OP_JMPREG: begin
        if (rm_register_i[3]) begin
          bytes[0] = rex(1'b0, 1'b0, 1'b0, 1'b1);
          bytes[1] = OPC_GRP5;
          bytes[2] = modrm(MOD_REG, EXT_JMP, rm_register_i[2:0]);
          len      = LEN_W'(3);
        end else begin
          bytes[0] = OPC_GRP5;
          bytes[1] = modrm(MOD_REG, EXT_JMP, rm_register_i[2:0]);
          len      = LEN_W'(2);
        end
      end
      OP_REGREG, OP_OPIMM: begin
        bytes[0] = rex(1'b1, reg_field_i[3], 1'b0, rm_register_i[3]);
        bytes[1] = opcode_byte_i;
        bytes[2] = modrm(MOD_REG, reg_field_i[2:0], rm_register_i[2:0]);
        if (op_e'(op_i) == OP_OPIMM) begin
          bytes[6:3] = imm32;
          len        = LEN_W'(7);
        end else begin
          len        = LEN_W'(3);
        end
      end
      OP_MEMSIB, OP_MEM: begin
        bytes[1] = opcode_byte_i;
        if (sib_form) begin
          bytes[0] = rex(1'b1, reg_field_i[3], sib_idx[3], rm_register_i[3]);
          bytes[2] = modrm(mem_mod, reg_field_i[2:0], RM_SIB);
          bytes[3] = {sib_scale, sib_idx[2:0], rm_register_i[2:0]};
          if (disp_s8) begin
            bytes[4] = disp[7:0];
            len      = LEN_W'(5);
          end else begin
            bytes[7:4] = disp;
            len        = LEN_W'(8);
          end
        end else begin
          bytes[0] = rex(1'b1, reg_field_i[3], 1'b0, rm_register_i[3]);
          bytes[2] = modrm(mem_mod, reg_field_i[2:0], rm_register_i[2:0]);
          if (disp_s8) begin
            bytes[3] = disp[7:0];
            len      = LEN_W'(4);
          end else begin
            bytes[6:3] = disp;
            len        = LEN_W'(7);
          end
        end
      end
      OP_PUSH: begin
        if (rm_register_i[3]) begin
          bytes[0] = rex(1'b0, 1'b0, 1'b0, 1'b1);
          bytes[1] = OPC_PUSH + {5'd0, rm_register_i[2:0]};
          len      = LEN_W'(2);
        end else begin
          bytes[0] = OPC_PUSH + {5'd0, rm_register_i[2:0]};
          len      = LEN_W'(1);
        end
      end
      OP_POP: begin
        bytes[0] = rex(1'b1, 1'b0, 1'b0, rm_register_i[3]);
        bytes[1] = OPC_POP_RM;
        bytes[2] = modrm(MOD_REG, EXT_POP, rm_register_i[2:0]);
        len      = LEN_W'(3);
      end
      OP_CMOVL: begin
        bytes[0] = rex(1'b1, reg_field_i[3], 1'b0, rm_register_i[3]);
        bytes[1] = OPC_ESC;
        bytes[2] = OPC_CMOVL;
        bytes[3] = modrm(MOD_REG, reg_field_i[2:0], rm_register_i[2:0]);
        len      = LEN_W'(4);
      end
      default: begin
        bytes = '0;
        len   = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || !q_full_i;
  assign take    = start_i && ready_o;
  assign push_o  = valid_q && !q_full_i;
  assign entry_o = entry_q;

  // drop requests that encode to nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= (len != '0);
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= '{bytes: bytes, len: len};
    end
  end

endmodule

[rtl/x64e_queue.sv]
// ----------------------------------------------------------------------------
// x64e_queue
// Small FIFO of encoded instructions between front and back.
// ----------------------------------------------------------------------------
module x64e_queue #(
  parameter int unsigned Depth = x64e_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  x64e_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output x64e_pkg::entry_t data_o
);
  import x64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/x64e_back.sv]
// ----------------------------------------------------------------------------
// x64e_back
// Takes encoded instructions from the queue and sends one byte per cycle.
// ----------------------------------------------------------------------------
module x64e_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  x64e_pkg::entry_t  q_data_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output x64e_pkg::result_t res_o
);
  import x64e_pkg::*;

  logic             active_q;
  entry_t           entry_q;
  logic [LEN_W-1:0] idx_q;
  logic             last_now;
  logic             res_valid_q;
  result_t          res_q;

  assign last_now = (idx_q == LEN_W'(entry_q.len - 1'b1));
  assign pop_o    = q_valid_i && (!active_q || last_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (active_q) begin
        if (last_now) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= q_data_i;
    end
    res_q <= '{code: entry_q.bytes[idx_q], pos: idx_q, last: last_now};
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
